// File: hdl/mec_pkg.sv
// Shared types, codes and helper functions for the Morse element classifier.
// No dependencies; imported by morse_element_classifier_top.
`default_nettype none

package mec_pkg;

    localparam int TIME_W  = 16;
    localparam int TOL_W   = 12;
    localparam int CFG_N   = 5;
    localparam int CFG_IW  = $clog2(CFG_N);
    localparam int SYM_W   = 3;
    localparam int MODE_W  = 2;

    // calibration products: width * 10000, width * 3366, width * 100 and width * 299
    localparam int CAL_W   = TIME_W + 14;
    // signed window compares: up to 7 * dot + tolerance
    localparam int WIN_W   = TIME_W + 5;

    localparam logic [MODE_W-1:0] MODE_RISE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FALL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECAL = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_DOT_SPACE  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CHAR_SPACE = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WORD_SPACE = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_DOT_PULSE  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DASH_PULSE = 3'd4;

    localparam logic [TOL_W-1:0] RST_DOT_SPACE  = 12'd6;
    localparam logic [TOL_W-1:0] RST_CHAR_SPACE = 12'd52;
    localparam logic [TOL_W-1:0] RST_WORD_SPACE = 12'd122;
    localparam logic [TOL_W-1:0] RST_DOT_PULSE  = 12'd1;
    localparam logic [TOL_W-1:0] RST_DASH_PULSE = 12'd10;

    localparam logic [CAL_W-1:0] CAL_SHORT_NUM = CAL_W'(10000);
    localparam logic [CAL_W-1:0] CAL_SHORT_DEN = CAL_W'(3366);
    localparam logic [CAL_W-1:0] CAL_LONG_NUM  = CAL_W'(100);
    localparam logic [CAL_W-1:0] CAL_LONG_DEN  = CAL_W'(299);

    typedef enum logic [2:0] {
        PH_CAL_RISE = 3'd0,
        PH_CAL_FALL = 3'd1,
        PH_EOC_RISE = 3'd2,
        PH_EOC_FALL = 3'd3,
        PH_DEC_RISE = 3'd4,
        PH_DEC_FALL = 3'd5
    } phase_t;

    typedef enum logic [SYM_W-1:0] {
        SYM_DOT        = 3'd0,
        SYM_DASH       = 3'd1,
        SYM_BAD_PULSE  = 3'd2,
        SYM_CHAR_END   = 3'd3,
        SYM_WORD_END   = 3'd4,
        SYM_BAD_SPACE  = 3'd5,
        SYM_CALIBRATED = 3'd6,
        SYM_NONE       = 3'd7
    } sym_t;

    function automatic logic in_window(
        input logic signed [WIN_W-1:0] v,
        input logic signed [WIN_W-1:0] base,
        input logic signed [WIN_W-1:0] tol,
        input logic                    inclusive
    );
        logic signed [WIN_W-1:0] lo;
        logic signed [WIN_W-1:0] hi;
        lo = base - tol;
        hi = base + tol;
        if (inclusive)
            return (v >= lo) && (v <= hi);
        return (v > lo) && (v < hi);
    endfunction

    function automatic logic signed [WIN_W-1:0] to_win(input logic [TIME_W-1:0] x);
        return $signed({{(WIN_W - TIME_W){1'b0}}, x});
    endfunction

    function automatic logic signed [WIN_W-1:0] tol_win(input logic [TOL_W-1:0] x);
        return $signed({{(WIN_W - TOL_W){1'b0}}, x});
    endfunction

endpackage

`default_nettype wire

// File: hdl/morse_element_classifier_top.sv
// Morse element classifier top level: request register, single-pass classifier, result register.
// Depends on mec_pkg.
`default_nettype none

// Takes line edges and recalibrate requests, one request per clock cycle unless a
// held result stalls them, and returns dot, dash, bad pulse, character end, word
// end or bad space symbols, or the calibrated symbol. A request sits in the input
// register, where it is classified by one pass of constant multiplies and signed
// window compares. When it advances, a request that yields a symbol lands in the
// result register, which drives out_valid. Throughput is one request per cycle while
// no result is held, set by the single-pass classifier that updates the phase
// and time-stamp state on every request. A request that yields no symbol still
// passes through the input register, and requests back up only while a result
// is held by out_ready low.
module morse_element_classifier_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [mec_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [mec_pkg::TOL_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mec_pkg::MODE_W-1:0]     mode,
    input  wire logic [mec_pkg::TIME_W-1:0]     time_stamp,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [mec_pkg::SYM_W-1:0]           symbol,
    output logic [mec_pkg::TIME_W-1:0]          event_time,
    output logic [mec_pkg::TIME_W-1:0]          dot_length
);
    import mec_pkg::*;

    logic [TOL_W-1:0]  dot_space_tol_reg;
    logic [TOL_W-1:0]  char_space_tol_reg;
    logic [TOL_W-1:0]  word_space_tol_reg;
    logic [TOL_W-1:0]  dot_pulse_tol_reg;
    logic [TOL_W-1:0]  dash_pulse_tol_reg;

    logic              s1_valid_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [TIME_W-1:0] s1_time_reg;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TIME_W-1:0] last_rise_reg;
    logic [TIME_W-1:0] last_rise_next;
    logic [TIME_W-1:0] last_fall_reg;
    logic [TIME_W-1:0] last_fall_next;
    logic [TIME_W-1:0] first_width_reg;
    logic [TIME_W-1:0] first_width_next;
    logic [TIME_W-1:0] learned_dot_reg;
    logic [TIME_W-1:0] learned_dot_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SYM_W-1:0]  symbol_reg;
    logic [TIME_W-1:0] event_time_reg;
    logic [TIME_W-1:0] dot_length_reg;

    sym_t              sym_next;
    sym_t              space_sym;
    sym_t              pulse_sym;
    logic              s1_advance;
    logic              rise;
    logic              fall;
    logic              recal;

    logic [TIME_W-1:0] space_w;
    logic [TIME_W-1:0] pulse_w;
    logic [CAL_W-1:0]  first_x_short;
    logic [CAL_W-1:0]  w_x_short;
    logic [CAL_W-1:0]  first_x_long;
    logic [CAL_W-1:0]  w_x_long;
    logic signed [WIN_W-1:0] sw;
    logic signed [WIN_W-1:0] pw;
    logic signed [WIN_W-1:0] d1;
    logic signed [WIN_W-1:0] d3;
    logic signed [WIN_W-1:0] d7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_space_tol_reg  <= RST_DOT_SPACE;
            char_space_tol_reg <= RST_CHAR_SPACE;
            word_space_tol_reg <= RST_WORD_SPACE;
            dot_pulse_tol_reg  <= RST_DOT_PULSE;
            dash_pulse_tol_reg <= RST_DASH_PULSE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DOT_SPACE:  dot_space_tol_reg  <= cfg_data;
                CFG_CHAR_SPACE: char_space_tol_reg <= cfg_data;
                CFG_WORD_SPACE: word_space_tol_reg <= cfg_data;
                CFG_DOT_PULSE:  dot_pulse_tol_reg  <= cfg_data;
                CFG_DASH_PULSE: dash_pulse_tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg <= mode;
            s1_time_reg <= time_stamp;
        end
    end

    assign rise  = (s1_mode_reg == MODE_RISE);
    assign fall  = (s1_mode_reg == MODE_FALL);
    assign recal = (s1_mode_reg == MODE_RECAL);

    assign space_w = s1_time_reg - last_fall_reg;
    assign pulse_w = s1_time_reg - last_rise_reg;

    assign first_x_short = CAL_W'(first_width_reg) * CAL_SHORT_NUM;
    assign w_x_short     = CAL_W'(pulse_w) * CAL_SHORT_DEN;
    assign first_x_long  = CAL_W'(first_width_reg) * CAL_LONG_NUM;
    assign w_x_long      = CAL_W'(pulse_w) * CAL_LONG_DEN;

    assign sw = to_win(space_w);
    assign pw = to_win(pulse_w);
    assign d1 = to_win(learned_dot_reg);
    assign d3 = d1 + (d1 <<< 1);
    assign d7 = (d1 <<< 3) - d1;

    always_comb
    begin
        if (in_window(sw, d1, tol_win(dot_space_tol_reg), 1'b0))
            space_sym = SYM_NONE;
        else if (in_window(sw, d3, tol_win(char_space_tol_reg), 1'b1))
            space_sym = SYM_CHAR_END;
        else if (in_window(sw, d7, tol_win(word_space_tol_reg), 1'b1))
            space_sym = SYM_WORD_END;
        else
            space_sym = SYM_BAD_SPACE;

        if (in_window(pw, d1, tol_win(dot_pulse_tol_reg), 1'b1))
            pulse_sym = SYM_DOT;
        else if (in_window(pw, d3, tol_win(dash_pulse_tol_reg), 1'b1))
            pulse_sym = SYM_DASH;
        else
            pulse_sym = SYM_BAD_PULSE;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        last_rise_next   = last_rise_reg;
        last_fall_next   = last_fall_reg;
        first_width_next = first_width_reg;
        learned_dot_next = learned_dot_reg;
        sym_next         = SYM_NONE;

        case (phase_reg)
            PH_CAL_RISE:
            begin
                if (rise)
                begin
                    last_rise_next = s1_time_reg;
                    phase_next     = PH_CAL_FALL;
                end
            end
            PH_CAL_FALL:
            begin
                if (fall)
                begin
                    last_fall_next = s1_time_reg;
                    phase_next     = PH_CAL_RISE;
                    if (first_width_reg == '0)
                        first_width_next = pulse_w;
                    else if (first_x_short <= w_x_short)
                    begin
                        learned_dot_next = first_width_reg;
                        sym_next         = SYM_CALIBRATED;
                        phase_next       = PH_EOC_RISE;
                    end
                    else if (first_x_long > w_x_long)
                    begin
                        learned_dot_next = pulse_w;
                        sym_next         = SYM_CALIBRATED;
                        phase_next       = PH_EOC_RISE;
                    end
                    else
                        first_width_next = pulse_w;
                end
            end
            PH_EOC_RISE, PH_DEC_RISE:
            begin
                if (rise)
                begin
                    last_rise_next = s1_time_reg;
                    sym_next       = space_sym;
                    if (phase_reg == PH_EOC_RISE && space_sym != SYM_CHAR_END)
                        phase_next = PH_EOC_FALL;
                    else
                        phase_next = PH_DEC_FALL;
                end
                else if (recal)
                begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            PH_EOC_FALL:
            begin
                if (fall)
                begin
                    last_fall_next = s1_time_reg;
                    phase_next     = PH_EOC_RISE;
                end
                else if (recal)
                begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            PH_DEC_FALL:
            begin
                if (fall)
                begin
                    last_fall_next = s1_time_reg;
                    phase_next     = PH_DEC_RISE;
                    sym_next       = pulse_sym;
                end
                else if (recal)
                begin
                    phase_next       = PH_CAL_RISE;
                    first_width_next = '0;
                end
            end
            default:
                phase_next = PH_CAL_RISE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CAL_RISE;
            last_rise_reg   <= '0;
            last_fall_reg   <= '0;
            first_width_reg <= '0;
            learned_dot_reg <= '0;
        end
        else if (s1_advance)
        begin
            phase_reg       <= phase_next;
            last_rise_reg   <= last_rise_next;
            last_fall_reg   <= last_fall_next;
            first_width_reg <= first_width_next;
            learned_dot_reg <= learned_dot_next;
        end
    end

    assign out_valid_next = (s1_advance && sym_next != SYM_NONE) ||
                            (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && sym_next != SYM_NONE)
        begin
            symbol_reg     <= sym_next;
            event_time_reg <= s1_time_reg;
            dot_length_reg <= learned_dot_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign symbol     = symbol_reg;
    assign event_time = event_time_reg;
    assign dot_length = dot_length_reg;

    a_no_idle_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol != SYM_NONE)
        else $error("result carries no symbol");

    a_cal_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && sym_next == SYM_CALIBRATED)
        |=> phase_reg == PH_EOC_RISE && dot_length == learned_dot_reg)
        else $error("calibration did not move to after-character phase");

    a_pulse_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (sym_next == SYM_DOT || sym_next == SYM_DASH ||
                        sym_next == SYM_BAD_PULSE))
        |-> phase_reg == PH_DEC_FALL && fall)
        else $error("pulse symbol outside decode fall");

    a_recal_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && recal && phase_reg != PH_CAL_RISE && phase_reg != PH_CAL_FALL)
        |=> phase_reg == PH_CAL_RISE && first_width_reg == '0)
        else $error("recalibrate request did not restart calibration");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("request stalled without a held result");

endmodule

`default_nettype wire

// File: bench/tb_morse_element_classifier_top.sv
`timescale 1ns / 100ps
// Self-checking bench for morse_element_classifier_top: line-edge requests in, symbols out.
// Depends on mec_pkg and the RTL top; keeps its own model of the calibration and decode rules.
// Covers directed edge cases, tolerance sweeps, long output hold-off and random edge traffic.

module tb_morse_element_classifier_top;

    import mec_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TRAILING_CYCLES = 10;
    localparam int RANDOM_REQUESTS = 560;
    localparam int QUIET_TAIL      = 120;

    typedef struct {
        sym_t              sym;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] dot_len;
    } symbol_rec_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [CFG_IW-1:0]   cfg_index;
    logic [TOL_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [TIME_W-1:0]   time_stamp;
    logic                out_valid;
    logic                out_ready;
    logic [SYM_W-1:0]    symbol;
    logic [TIME_W-1:0]   event_time;
    logic [TIME_W-1:0]   dot_length;

    symbol_rec_t       pending_symbols [$];
    symbol_rec_t       oldest_symbol;
    int                mismatches = 0;
    int                requests_sent = 0;
    int                idle_cycles = 0;
    bit                gaps_on = 1'b1;
    bit                stalls_on = 1'b1;
    bit                hold_off_request = 1'b0;
    logic [TIME_W-1:0] line_time;

    phase_t            phase_now = PH_CAL_RISE;
    logic [TIME_W-1:0] rise_t = '0;
    logic [TIME_W-1:0] fall_t = '0;
    logic [TIME_W-1:0] first_w = '0;
    logic [TIME_W-1:0] dot_now = '0;
    logic [TOL_W-1:0]  tol_reg [CFG_N] = '{RST_DOT_SPACE, RST_CHAR_SPACE, RST_WORD_SPACE,
                                          RST_DOT_PULSE, RST_DASH_PULSE};

    morse_element_classifier_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .time_stamp (time_stamp),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .symbol     (symbol),
        .event_time (event_time),
        .dot_length (dot_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit in_band(input longint v, input longint center, input longint tol,
                                   input bit inclusive);
        if (inclusive)
            return (v >= center - tol) && (v <= center + tol);
        return (v > center - tol) && (v < center + tol);
    endfunction

    function automatic void predict_symbol(input logic [MODE_W-1:0] m,
                                           input logic [TIME_W-1:0] t);
        sym_t              s;
        logic [TIME_W-1:0] w;
        longint            d;
        s = SYM_NONE;
        d = longint'(dot_now);
        case (phase_now)
            PH_CAL_RISE:
            begin
                if (m == MODE_RISE)
                begin
                    rise_t    = t;
                    phase_now = PH_CAL_FALL;
                end
            end
            PH_CAL_FALL:
            begin
                if (m == MODE_FALL)
                begin
                    fall_t    = t;
                    phase_now = PH_CAL_RISE;
                    w         = fall_t - rise_t;
                    if (first_w == '0)
                        first_w = w;
                    else if (longint'(first_w) * 10000 <= longint'(w) * 3366)
                    begin
                        dot_now = first_w;
                        s       = SYM_CALIBRATED;
                    end
                    else if (longint'(first_w) * 100 > longint'(w) * 299)
                    begin
                        dot_now = w;
                        s       = SYM_CALIBRATED;
                    end
                    else
                        first_w = w;
                    if (s == SYM_CALIBRATED)
                        phase_now = PH_EOC_RISE;
                end
            end
            PH_EOC_RISE, PH_DEC_RISE:
            begin
                if (m == MODE_RISE)
                begin
                    rise_t = t;
                    w      = rise_t - fall_t;
                    if (in_band(longint'(w), d, longint'(tol_reg[CFG_DOT_SPACE]), 1'b0))
                        s = SYM_NONE;
                    else if (in_band(longint'(w), 3 * d, longint'(tol_reg[CFG_CHAR_SPACE]), 1'b1))
                        s = SYM_CHAR_END;
                    else if (in_band(longint'(w), 7 * d, longint'(tol_reg[CFG_WORD_SPACE]), 1'b1))
                        s = SYM_WORD_END;
                    else
                        s = SYM_BAD_SPACE;
                    if (phase_now == PH_EOC_RISE && s != SYM_CHAR_END)
                        phase_now = PH_EOC_FALL;
                    else
                        phase_now = PH_DEC_FALL;
                end
                else if (m == MODE_RECAL)
                begin
                    phase_now = PH_CAL_RISE;
                    first_w   = '0;
                end
            end
            PH_EOC_FALL:
            begin
                if (m == MODE_FALL)
                begin
                    fall_t    = t;
                    phase_now = PH_EOC_RISE;
                end
                else if (m == MODE_RECAL)
                begin
                    phase_now = PH_CAL_RISE;
                    first_w   = '0;
                end
            end
            PH_DEC_FALL:
            begin
                if (m == MODE_FALL)
                begin
                    fall_t    = t;
                    phase_now = PH_DEC_RISE;
                    w         = fall_t - rise_t;
                    if (in_band(longint'(w), d, longint'(tol_reg[CFG_DOT_PULSE]), 1'b1))
                        s = SYM_DOT;
                    else if (in_band(longint'(w), 3 * d, longint'(tol_reg[CFG_DASH_PULSE]), 1'b1))
                        s = SYM_DASH;
                    else
                        s = SYM_BAD_PULSE;
                end
                else if (m == MODE_RECAL)
                begin
                    phase_now = PH_CAL_RISE;
                    first_w   = '0;
                end
            end
            default:
                phase_now = PH_CAL_RISE;
        endcase
        if (s != SYM_NONE)
            pending_symbols.push_back('{sym: s, stamp: t, dot_len: dot_now});
    endfunction

    function automatic logic [TOL_W-1:0] pick_tolerance();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return TOL_W'($urandom_range(0, 20));
            default: return TOL_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] element_width(input int unsigned dot, input bit is_space);
        int m;
        int tol;
        int off;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                m   = 1;
                tol = is_space ? int'(tol_reg[CFG_DOT_SPACE]) : int'(tol_reg[CFG_DOT_PULSE]);
            end
            2, 3:
            begin
                m   = 3;
                tol = is_space ? int'(tol_reg[CFG_CHAR_SPACE]) : int'(tol_reg[CFG_DASH_PULSE]);
            end
            4:
            begin
                m   = is_space ? 7 : 3;
                tol = is_space ? int'(tol_reg[CFG_WORD_SPACE]) : int'(tol_reg[CFG_DASH_PULSE]);
            end
            default:
                return TIME_W'($urandom_range(0, 8 * dot + 16));
        endcase
        case ($urandom_range(0, 4))
            0:       off = 0;
            1:       off = tol;
            2:       off = tol + 1;
            3:       off = tol - 1;
            default: off = int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
        endcase
        if ($urandom_range(0, 1) == 1)
            off = -off;
        return TIME_W'(m * int'(dot) + off);
    endfunction

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [TIME_W-1:0] t);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        time_stamp <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_symbol(m, t);
        requests_sent++;
    endtask

    task automatic send_mark(input logic [TIME_W-1:0] space, input logic [TIME_W-1:0] width);
        line_time = line_time + space;
        send_request(MODE_RISE, line_time);
        line_time = line_time + width;
        send_request(MODE_FALL, line_time);
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [CFG_IW-1:0] idx, input logic [TOL_W-1:0] val);
        @(negedge clk);
        cfg_write    <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        tol_reg[idx] = val;
    endtask

    task automatic set_tolerances(input logic [TOL_W-1:0] dot_space,
                                  input logic [TOL_W-1:0] char_space,
                                  input logic [TOL_W-1:0] word_space,
                                  input logic [TOL_W-1:0] dot_pulse,
                                  input logic [TOL_W-1:0] dash_pulse);
        drain_and_settle();
        write_tolerance(CFG_DOT_SPACE, dot_space);
        write_tolerance(CFG_CHAR_SPACE, char_space);
        write_tolerance(CFG_WORD_SPACE, word_space);
        write_tolerance(CFG_DOT_PULSE, dot_pulse);
        write_tolerance(CFG_DASH_PULSE, dash_pulse);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_session(input int n_elements);
        int unsigned dot;
        int unsigned k;
        int          i;
        send_request(MODE_RECAL, line_time);
        dot = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 8000) : $urandom_range(2, 150);
        k   = $urandom_range(3, 7);
        if ($urandom_range(0, 2) == 0)
            send_mark(TIME_W'($urandom_range(1, 3 * dot)), TIME_W'(dot));
        if ($urandom_range(0, 1) == 1)
        begin
            send_mark(TIME_W'($urandom_range(1, 3 * dot)), TIME_W'(dot));
            send_mark(TIME_W'($urandom_range(1, 3 * dot)), TIME_W'(k * dot));
        end
        else
        begin
            send_mark(TIME_W'($urandom_range(1, 3 * dot)), TIME_W'(k * dot));
            send_mark(TIME_W'($urandom_range(1, 3 * dot)), TIME_W'(dot));
        end
        for (i = 0; i < n_elements; i++)
        begin
            case ($urandom_range(0, 15))
                0:       send_request(MODE_W'($urandom_range(0, 3)), TIME_W'($urandom));
                1:       send_request(MODE_W'($urandom_range(0, 3)), line_time);
                default: send_mark(element_width(dot, 1'b1), element_width(dot, 1'b0));
            endcase
        end
    endtask

    task automatic test_directed_edges();
        send_request(MODE_FALL, 16'd5);
        send_request(MODE_RECAL, 16'd7);
        send_request(MODE_UNUSED, 16'd9);
        send_request(MODE_RISE, 16'd65530);
        send_request(MODE_FALL, 16'd4);
        send_request(MODE_RISE, 16'd100);
        send_request(MODE_FALL, 16'd130);
        send_request(MODE_RISE, 16'd145);
        send_request(MODE_RISE, 16'd150);
        send_request(MODE_FALL, 16'd160);
        send_request(MODE_RISE, 16'd190);
        send_request(MODE_FALL, 16'd200);
        send_request(MODE_RISE, 16'd210);
        send_request(MODE_RISE, 16'd215);
        send_request(MODE_FALL, 16'd240);
        send_request(MODE_RISE, 16'd65535);
        send_request(MODE_FALL, 16'd65535);
        send_request(MODE_RECAL, 16'd0);
        send_request(MODE_RISE, 16'd0);
        send_request(MODE_FALL, 16'd0);
        send_request(MODE_RISE, 16'd10);
        send_request(MODE_FALL, 16'd30);
        send_request(MODE_RISE, 16'd40);
        send_request(MODE_FALL, 16'd40);
        send_request(MODE_UNUSED, 16'd65535);
    endtask

    task automatic test_tolerance_extremes();
        set_tolerances('0, '0, '0, '0, '0);
        run_session(12);
        set_tolerances('1, '1, '1, '1, '1);
        run_session(12);
        set_tolerances('1, '0, '1, '0, '1);
        run_session(12);
        set_tolerances(pick_tolerance(), pick_tolerance(), pick_tolerance(),
                       pick_tolerance(), pick_tolerance());
        run_session(12);
        set_tolerances(RST_DOT_SPACE, RST_CHAR_SPACE, RST_WORD_SPACE, RST_DOT_PULSE,
                       RST_DASH_PULSE);
        run_session(12);
    endtask

    task automatic test_output_hold_off();
        gaps_on          = 1'b0;
        hold_off_request = 1'b1;
        run_session(30);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int  target;
        bit  quiet;
        bit  tail;
        target = requests_sent + RANDOM_REQUESTS;
        while (requests_sent < target)
        begin
            tail      = (requests_sent >= target - QUIET_TAIL);
            quiet     = ($urandom_range(0, 3) == 0) || tail;
            gaps_on   = !quiet;
            stalls_on = !quiet;
            if (!tail && $urandom_range(0, 3) == 0)
                set_tolerances(pick_tolerance(), pick_tolerance(), pick_tolerance(),
                               pick_tolerance(), pick_tolerance());
            run_session($urandom_range(8, 30));
        end
    endtask

    initial
    begin : ready_driver
        out_ready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got symbol %0d time %0d dot %0d",
                         $time, symbol, event_time, dot_length);
                mismatches++;
            end
            else
            begin
                oldest_symbol = pending_symbols.pop_front();
                if (symbol !== oldest_symbol.sym)
                begin
                    $display("%0t: symbol mismatch, expected %0d, got %0d",
                             $time, oldest_symbol.sym, symbol);
                    mismatches++;
                end
                if (event_time !== oldest_symbol.stamp)
                begin
                    $display("%0t: event_time mismatch, expected %0d, got %0d",
                             $time, oldest_symbol.stamp, event_time);
                    mismatches++;
                end
                if (dot_length !== oldest_symbol.dot_len)
                begin
                    $display("%0t: dot_length mismatch, expected %0d, got %0d",
                             $time, oldest_symbol.dot_len, dot_length);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_DOT_SPACE;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        mode       <= MODE_RISE;
        time_stamp <= '0;
        line_time  = TIME_W'($urandom);
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_tolerance_extremes();
        test_output_hold_off();
        test_random_traffic();

        drain_and_settle();
        repeat (TRAILING_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_symbols.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/mec_pkg.sv
hdl/morse_element_classifier_top.sv
bench/tb_morse_element_classifier_top.sv
